FILE: rtl/tsfl_pkg.sv
// tsfl_pkg: command and status codes plus default sizes for the tag slot manager.
// No dependencies.
package tsfl_pkg;

    localparam int TAG_SLOTS_DEF  = 256;
    localparam int DATA_SLOTS_DEF = 512;
    localparam int ADDR_BITS_DEF  = 48;

    localparam int CMD_W  = 3;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_ALLOC  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_FREE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd2;
    localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [STAT_W-1:0] ST_MISS    = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOT_USE = 2'd3;

endpackage

FILE: rtl/tag_slot_free_list_manager.sv
// Timing: the request is latched on accept, and the result is registered from the execute
// state, or from the scan state for a lookup, which walks the entries from slot 0 to the
// lowest matching slot (TAG_SLOTS - 1 on a miss), one entry-RAM read a cycle. Output stall
// holds the request in execute or scan until the result register frees up. Throughput: one
// request in flight; no new request is accepted until the last one's result is loaded.
// Reset (i_rst_n low, synchronous): all slots free, slot 0 pops first, all entries
// invalid. Untouched stack positions read as their reset slot via a low-water mark,
// so no clearing pass is needed. Depends on tsfl_pkg.
module tag_slot_free_list_manager
    import tsfl_pkg::*;
#(
    parameter int TAG_SLOTS  = TAG_SLOTS_DEF,
    parameter int DATA_SLOTS = DATA_SLOTS_DEF,
    parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [CMD_W-1:0]              i_command,
    input  logic [ADDR_BITS-1:0]          i_tag_address,
    input  logic [$clog2(TAG_SLOTS)-1:0]  i_slot_index,
    input  logic                          i_is_delta,
    input  logic                          i_delta_direction,
    input  logic [ADDR_BITS-1:0]          i_base_address,
    input  logic [$clog2(DATA_SLOTS)-1:0] i_data_slot,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [STAT_W-1:0]             o_status,
    output logic [$clog2(TAG_SLOTS)-1:0]  o_result_slot,
    output logic [ADDR_BITS-1:0]          o_entry_tag,
    output logic                          o_entry_valid,
    output logic                          o_entry_is_delta,
    output logic                          o_entry_direction,
    output logic [ADDR_BITS-1:0]          o_entry_base,
    output logic [$clog2(DATA_SLOTS)-1:0] o_entry_data_slot,
    output logic [$clog2(TAG_SLOTS+1)-1:0] o_free_count
);

    localparam int SLOT_W = $clog2(TAG_SLOTS);
    localparam int DATA_W = $clog2(DATA_SLOTS);
    localparam int CNT_W  = $clog2(TAG_SLOTS + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(TAG_SLOTS);

    // Sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_SCAN = 2'd2;

    // Entry payload other than the tag; allocate rewrites only the tag.
    typedef struct packed {
        logic              is_delta;
        logic              dir;
        logic [ADDR_BITS-1:0] base;
        logic [DATA_W-1:0] data;
    } t_info;

    // Memories: entry RAM (tag and info lanes, separate write enables) and stack RAM.
    logic [ADDR_BITS-1:0] tag_mem  [TAG_SLOTS];
    t_info                info_mem [TAG_SLOTS];
    logic [SLOT_W-1:0]    stk_mem  [TAG_SLOTS];

    logic [ADDR_BITS-1:0] r_tag_q;
    t_info                r_info_q;
    logic [SLOT_W-1:0]    r_stk_q;

    // Valid marks in flops so they clear at reset.
    logic [TAG_SLOTS-1:0] r_vld, n_vld;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_depth, n_depth;
    logic [CNT_W-1:0]  r_low, n_low;   // lowest depth seen since reset
    logic [SLOT_W-1:0] r_scan, n_scan;

    // Latched request
    logic [CMD_W-1:0]     r_cmd;
    logic [ADDR_BITS-1:0] r_tag;
    logic [SLOT_W-1:0]    r_idx;
    t_info                r_info;

    logic [STAT_W-1:0]    n_status;
    logic [SLOT_W-1:0]    n_rslot;
    logic                 n_rd_entry;

    logic                 accept, out_free, load;
    logic                 rd_en;
    logic [SLOT_W-1:0]    rd_addr;
    logic                 tag_we, info_we, stk_we;
    logic [SLOT_W-1:0]    wr_addr;
    logic [SLOT_W-1:0]    stk_addr;
    logic                 idx_ok;

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !o_valid || !i_stall;
    assign idx_ok   = ({1'b0, r_idx} < (SLOT_W + 1)'(TAG_SLOTS));

    always_comb begin
        n_state    = r_state;
        n_depth    = r_depth;
        n_low      = r_low;
        n_scan     = r_scan;
        n_vld      = r_vld;
        n_status   = ST_OK;
        n_rslot    = '0;
        n_rd_entry = 1'b0;
        load       = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = '0;
        tag_we     = 1'b0;
        info_we    = 1'b0;
        stk_we     = 1'b0;
        wr_addr    = r_idx;
        stk_addr   = SLOT_W'(r_depth - 1'b1);
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    rd_en   = 1'b1;
                    rd_addr = (i_command == CMD_READ) ? i_slot_index : '0;
                    n_scan  = '0;
                    n_state = (i_command == CMD_LOOKUP) ? S_SCAN : S_EXEC;
                end
            end
            S_EXEC: begin
                case (r_cmd)
                    CMD_ALLOC: begin
                        if (r_depth == '0) begin
                            n_status = ST_NO_FREE;
                        end else begin
                            // positions below the low-water mark still hold reset order
                            n_rslot = (r_depth <= r_low) ? SLOT_W'(FULL - r_depth) : r_stk_q;
                            if (out_free) begin
                                n_depth = r_depth - 1'b1;
                                if (r_depth - 1'b1 < r_low) n_low = r_depth - 1'b1;
                                tag_we  = 1'b1;
                                wr_addr = n_rslot;
                                n_vld[n_rslot] = 1'b1;
                            end
                        end
                    end
                    CMD_FREE: begin
                        if (!idx_ok || !r_vld[r_idx] || r_depth >= FULL) begin
                            n_status = ST_NOT_USE;
                        end else if (out_free) begin
                            n_vld[r_idx] = 1'b0;
                            stk_we   = 1'b1;
                            stk_addr = SLOT_W'(r_depth);
                            n_depth  = r_depth + 1'b1;
                        end
                    end
                    CMD_WRITE: begin
                        if (!idx_ok || !r_vld[r_idx]) begin
                            n_status = ST_NOT_USE;
                        end else if (out_free) begin
                            tag_we  = 1'b1;
                            info_we = 1'b1;
                        end
                    end
                    CMD_READ: begin
                        if (!idx_ok) n_status = ST_NOT_USE;
                        else         n_rd_entry = 1'b1;
                    end
                    default: ;
                endcase
                if (out_free) begin
                    load    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (r_vld[r_scan] && r_tag_q == r_tag) begin
                    n_rslot = r_scan;
                    if (out_free) begin
                        load    = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if ({1'b0, r_scan} == (SLOT_W + 1)'(TAG_SLOTS - 1)) begin
                    n_status = ST_MISS;
                    if (out_free) begin
                        load    = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_scan + 1'b1;
                    n_scan  = r_scan + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Entry RAM: one read port, lane-masked write port
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_tag_q  <= tag_mem[rd_addr];
            r_info_q <= info_mem[rd_addr];
        end
        if (tag_we)  tag_mem[wr_addr]  <= r_tag;
        if (info_we) info_mem[wr_addr] <= r_info;
    end

    // Stack RAM: read top on accept, push on free
    always_ff @(posedge i_clk) begin
        if (accept) r_stk_q <= stk_mem[stk_addr];
        if (stk_we) stk_mem[stk_addr] <= r_idx;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_command;
            r_tag  <= i_tag_address;
            r_idx  <= i_slot_index;
            r_info <= '{is_delta: i_is_delta, dir: i_delta_direction,
                        base: i_base_address, data: i_data_slot};
        end
        if (load) begin
            o_status          <= n_status;
            o_result_slot     <= n_rslot;
            o_free_count      <= n_depth;
            o_entry_tag       <= n_rd_entry ? r_tag_q : '0;
            o_entry_valid     <= n_rd_entry ? r_vld[r_idx] : 1'b0;
            o_entry_is_delta  <= n_rd_entry ? r_info_q.is_delta : 1'b0;
            o_entry_direction <= n_rd_entry ? r_info_q.dir : 1'b0;
            o_entry_base      <= n_rd_entry ? r_info_q.base : '0;
            o_entry_data_slot <= n_rd_entry ? r_info_q.data : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_depth <= FULL;
            r_low   <= FULL;
            r_scan  <= '0;
            r_vld   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_low   <= n_low;
            r_scan  <= n_scan;
            r_vld   <= n_vld;
            if (load)          o_valid <= 1'b1;
            else if (!i_stall) o_valid <= 1'b0;
        end
    end

endmodule
